// File: design/ppe_pkg.sv
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants
// Payload structs, operation codes and sequencer states used by the
// piecewise polynomial evaluator and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppe_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_WRITE_BP    = 2'd0,
        OP_WRITE_COEFF = 2'd1,
        OP_EVALUATE    = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SEGMENTS = 2'd0,
        CFG_PERIODIC = 2'd1,
        CFG_UNUSED_2 = 2'd2,
        CFG_UNUSED_3 = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [4:0]        table_index;
        logic [1:0]        coeff_power;
        logic signed [31:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         segment_found;
        logic               overflow_flag;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PER_RD,
        ST_PER_WAIT,
        ST_PER_DIV,
        ST_PER_FIX,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HORN_RD,
        ST_HORN_LOAD,
        ST_HORN_MUL,
        ST_HORN_ADD,
        ST_OUT
    } state_t;

    // 33-bit remainder unit handshake.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: design/ppe_ram.sv
// ----------------------------------------------------------------------------
// ppe_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/ppe_mod.sv
// ----------------------------------------------------------------------------
// ppe_mod: iterative remainder unit
// Computes the magnitude remainder of a 33-bit dividend by a positive
// 33-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppe_mod
    import ppe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_ctrl_t   ctrl,
    input  wire logic [32:0] dividend_mag,
    input  wire logic [32:0] divisor,
    output div_stat_t        stat,
    output logic [32:0]      remainder
);

    logic [32:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[32]} - {1'b0, divisor};
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend_mag;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[32]};
            end
            quo_next = {quo_reg[31:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.done = busy_reg && (cnt_reg == 6'd1);
    assign remainder = rem_next;

endmodule

`default_nettype wire

// File: design/piecewise_poly_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_poly_evaluator: piecewise polynomial evaluator, Q16.16
// Holds breakpoint and coefficient tables, binary-searches the segment of an
// abscissa and evaluates its polynomial by Horner's rule with saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_stall    in_item_t
//  out       output     out_valid/out_stall  out_item_t
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// Write items go into the tables as they are accepted. An evaluate item runs
// the binary search and then the Horner steps before its result is passed
// to the output register. Periodic mode first adds steps to fetch the span
// and, when the period is positive, a bit-serial remainder. With zero
// segments the sequencer goes straight to its output step. The Horner steps
// share one coefficient read port, one multiplier and one adder under the
// sequencer. Reset clears the sequencer state, the output valid and the
// configuration registers; the datapath registers and tables are not cleared.
// The block takes no new item while an item is in work; a waiting result does
// not block the input, but the sequencer holds in its output step until the
// output register is free.
`default_nettype none

module piecewise_poly_evaluator
    import ppe_pkg::*;
#(
    parameter int MAX_SEGMENTS = 16,
    parameter int POLY_ORDER   = 3,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item,
    input  wire logic      cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    localparam int TERMS    = POLY_ORDER + 1;
    localparam int BP_DEPTH = MAX_SEGMENTS + 1;
    localparam int CO_DEPTH = MAX_SEGMENTS * TERMS;
    localparam int BP_AW    = $clog2(BP_DEPTH);
    localparam int CO_AW    = (CO_DEPTH > 1) ? $clog2(CO_DEPTH) : 1;
    localparam int SEG_W    = $clog2(BP_DEPTH);
    localparam int PW_W     = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int CO_DEPTH_P = 1 << CO_AW;

    state_t state_reg, state_next;

    logic [4:0]         nseg_reg;
    logic               per_reg;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [SEG_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [PW_W:0]      k_reg, k_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [63:0] prod_reg, prod_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [SEG_W-1:0] nclamp;
    logic [SEG_W-1:0] mid;
    logic             accept;

    logic             bp_we;
    logic [BP_AW-1:0] bp_wa, bp_ra;
    logic [31:0]      bp_rd;
    logic             co_we;
    logic [CO_AW-1:0] co_wa, co_ra;
    logic [31:0]      co_rd;

    div_ctrl_t   dctrl;
    div_stat_t   dstat;
    logic [32:0] diff, period, dmag, drem;
    logic signed [33:0] sum34;
    logic signed [32:0] rsigned;

    assign nclamp = (nseg_reg > 5'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : SEG_W'(nseg_reg);
    assign mid    = SEG_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Table ports: writes come straight from accepted items.
    assign bp_we = accept && (in_item.operation == OP_WRITE_BP)
                   && (32'(in_item.table_index) < 32'(BP_DEPTH));
    assign bp_wa = BP_AW'(in_item.table_index);
    assign co_we = accept && (in_item.operation == OP_WRITE_COEFF)
                   && (32'(in_item.table_index) < 32'(MAX_SEGMENTS))
                   && (32'(in_item.coeff_power) <= 32'(POLY_ORDER));
    assign co_wa = CO_AW'(32'(in_item.table_index) * TERMS + 32'(in_item.coeff_power));

    // The first breakpoint is read while idle; the last one is read in the
    // ST_PER_RD and ST_PER_WAIT steps so that it is on the read data when the
    // period is formed.
    always_comb
    begin
        unique case (state_reg)
            ST_PER_RD:   bp_ra = BP_AW'(nclamp);
            ST_PER_WAIT: bp_ra = BP_AW'(nclamp);
            ST_SRCH_RD:  bp_ra = BP_AW'(mid);
            default:     bp_ra = '0;
        endcase
        co_ra = CO_AW'(32'(lo_reg) * TERMS + 32'(k_reg));
    end

    ppe_ram #(.WIDTH(32), .DEPTH(BP_DEPTH)) u_bp (
        .clk(clk), .wr_en(bp_we), .wr_addr(bp_wa), .wr_data(in_item.data_word),
        .rd_addr(bp_ra), .rd_data(bp_rd)
    );

    ppe_ram #(.WIDTH(32), .DEPTH(CO_DEPTH_P)) u_co (
        .clk(clk), .wr_en(co_we), .wr_addr(co_wa), .wr_data(in_item.data_word),
        .rd_addr(co_ra), .rd_data(co_rd)
    );

    // Remainder of (x - first) by the period, on magnitudes.
    assign diff   = 33'({x_reg[31], x_reg} - {first_reg[31], first_reg});
    assign period = 33'({bp_rd[31], bp_rd} - {first_reg[31], first_reg});
    assign dmag   = diff[32] ? 33'(-diff) : diff;
    assign dctrl.start = (state_reg == ST_PER_DIV) && (state_next == ST_PER_FIX);

    logic [32:0] per_hold_reg, per_hold_next;

    ppe_mod u_mod (
        .clk(clk), .rst_n(rst_n), .ctrl(dctrl), .dividend_mag(dmag),
        .divisor(per_hold_reg), .stat(dstat), .remainder(drem)
    );

    assign rsigned = diff[32] ? ((drem == '0) ? 33'sd0 : $signed(per_hold_reg - drem))
                              : $signed(drem);
    assign sum34   = 34'(first_reg) + 34'(rsigned);

    // Horner arithmetic: floor shift then add and saturate.
    logic signed [63:0] shifted;
    logic signed [64:0] hsum;
    assign shifted = prod_reg >>> FRAC_BITS;
    assign hsum    = 65'(shifted) + 65'($signed(co_rd));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.operation == OP_EVALUATE)
                begin
                    if (nclamp == '0)
                        state_next = ST_OUT;
                    else if (per_reg)
                        state_next = ST_PER_RD;
                    else
                        state_next = ST_SRCH_RD;
                end
            end
            ST_PER_RD:   state_next = ST_PER_WAIT;
            ST_PER_WAIT: state_next = ST_PER_DIV;
            ST_PER_DIV:  state_next = period[32] || period == '0 ? ST_SRCH_RD : ST_PER_FIX;
            ST_PER_FIX:  if (dstat.done) state_next = ST_SRCH_RD;
            ST_SRCH_RD:
            begin
                if (32'(hi_reg) - 32'(lo_reg) > 1)
                    state_next = ST_SRCH_CMP;
                else
                    state_next = ST_HORN_LOAD;
            end
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_HORN_RD:  state_next = ST_HORN_MUL;
            ST_HORN_LOAD: state_next = (POLY_ORDER == 0) ? ST_OUT : ST_HORN_RD;
            ST_HORN_MUL: state_next = ST_HORN_ADD;
            ST_HORN_ADD: state_next = (k_reg == '0) ? ST_OUT : ST_HORN_RD;
            ST_OUT:      state_next = (out_valid_reg && out_stall) ? ST_OUT : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        x_next         = x_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        ovf_next       = ovf_reg;
        first_next     = first_reg;
        prod_next      = prod_reg;
        per_hold_next  = per_hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                x_next   = in_item.data_word;
                lo_next  = '0;
                hi_next  = nclamp;
                k_next   = (PW_W+1)'(POLY_ORDER);
                ovf_next = 1'b0;
                acc_next = '0;
            end
            ST_PER_RD:   first_next = $signed(bp_rd);
            ST_PER_WAIT: ;
            ST_PER_DIV:  per_hold_next = period;
            ST_PER_FIX:  if (dstat.done) x_next = 32'(sum34);
            ST_SRCH_RD:  ;
            ST_SRCH_CMP:
            begin
                if (x_reg < $signed(bp_rd))
                    hi_next = mid;
                else
                    lo_next = mid;
            end
            ST_HORN_LOAD:
            begin
                acc_next = $signed(co_rd);
                k_next   = k_reg - 1'b1;
            end
            ST_HORN_RD:  ;
            ST_HORN_MUL: prod_next = acc_reg * x_reg;
            ST_HORN_ADD:
            begin
                if (hsum > 65'sh7FFFFFFF)
                begin
                    acc_next = 32'sh7FFFFFFF;
                    ovf_next = 1'b1;
                end
                else if (hsum < -65'sh80000000)
                begin
                    acc_next = -32'sh80000000;
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = 32'(hsum);
                end
                if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            ST_OUT:
            begin
                // The result moves out only once the output register is free.
                if (!(out_valid_reg && out_stall))
                begin
                    out_next.result_value  = acc_reg;
                    out_next.segment_found = 4'(lo_reg);
                    out_next.overflow_flag = ovf_reg;
                    out_valid_next         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            nseg_reg      <= '0;
            per_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == 1'(CFG_SEGMENTS))
                nseg_reg <= cfg_data;
            if (cfg_we && cfg_index == 1'(CFG_PERIODIC))
                per_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        k_reg        <= k_next;
        ovf_reg      <= ovf_next;
        first_reg    <= first_next;
        prod_reg     <= prod_next;
        per_hold_reg <= per_hold_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire
